/* src/tafsm_pkg.sv */
// ----------------------------------------------------------------------------
// tafsm_pkg
// Shared types and constants for the temperature alarm state machine:
// field widths, register indexes, reset values and the state encoding.
// ----------------------------------------------------------------------------
package tafsm_pkg;

    localparam int TEMP_W  = 12;
    localparam int NOW_W   = 32;
    localparam int DWELL_W = 32;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PRE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALM_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_DWELL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALM_DWELL = 2'd3;

    localparam logic signed [TEMP_W-1:0] PRE_THR_RST   = 12'sd480;
    localparam logic signed [TEMP_W-1:0] ALM_THR_RST   = 12'sd800;
    localparam logic [DWELL_W-1:0]       PRE_DWELL_RST = 32'd5000;
    localparam logic [DWELL_W-1:0]       ALM_DWELL_RST = 32'd5000;

    localparam logic [MODE_W-1:0] CODE_NORMAL      = 3'd0;
    localparam logic [MODE_W-1:0] CODE_TRACK_PRE   = 3'd1;
    localparam logic [MODE_W-1:0] CODE_PRE         = 3'd2;
    localparam logic [MODE_W-1:0] CODE_TRACK_ALARM = 3'd3;
    localparam logic [MODE_W-1:0] CODE_ALARM       = 3'd4;

    typedef enum logic [4:0] {
        ST_NORMAL      = 5'b00001,
        ST_TRACK_PRE   = 5'b00010,
        ST_PRE         = 5'b00100,
        ST_TRACK_ALARM = 5'b01000,
        ST_ALARM       = 5'b10000
    } mode_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] prealarm_threshold;
        logic signed [TEMP_W-1:0] alarm_threshold;
        logic [DWELL_W-1:0]       prealarm_dwell_ms;
        logic [DWELL_W-1:0]       alarm_dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [NOW_W-1:0]         now_ms;
        logic                     button_pressed;
    } item_t;

    typedef struct packed {
        logic              prealarm_flag;
        logic              alarm_flag;
        logic [MODE_W-1:0] mode_code;
        logic              alarm_report;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_to_code(input mode_t m);
        logic [MODE_W-1:0] c;
        unique case (m)
            ST_TRACK_PRE:   c = CODE_TRACK_PRE;
            ST_PRE:         c = CODE_PRE;
            ST_TRACK_ALARM: c = CODE_TRACK_ALARM;
            ST_ALARM:       c = CODE_ALARM;
            default:        c = CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

/* src/temperature_alarm_fsm.sv */
// ----------------------------------------------------------------------------
// temperature_alarm_fsm
// Thermal alarm monitor, top level.
//
// Each item on the s_ channel is one tick: a temperature sample, the current
// millisecond time and the button level. Every accepted item gives exactly
// one result item on the m_ channel: the two indication flags, the state
// after the tick and whether the tick ran in the alarm state.
// Thresholds and dwell times are written over the cfg_ channel, which is
// always ready; write it only while no item is in flight.
// An accepted item passes through the input register, then through the state
// transition into the result register, which drives m_valid. Throughput is
// one item per cycle while the result register is free or m_ready is high.
// If m_ready is low the result register holds, the input register still
// takes one more item, and s_ready falls only when both are full.
// Reset (aresetn low, synchronous) empties both registers, puts the state
// machine in normal with its entry action pending and restores the register
// defaults.
// ----------------------------------------------------------------------------
module temperature_alarm_fsm
    import tafsm_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TEMP_W-1:0]     s_temperature,
    input  logic [NOW_W-1:0]      s_now_ms,
    input  logic                  s_button_pressed,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_prealarm_flag,
    output logic                  m_alarm_flag,
    output logic [MODE_W-1:0]     m_mode_code,
    output logic                  m_alarm_report
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_load;
    logic    step;

    tafsm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_load = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;

    tafsm_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.temperature    <= s_temperature;
            in_reg.now_ms         <= s_now_ms;
            in_reg.button_pressed <= s_button_pressed;
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_prealarm_flag = res_reg.prealarm_flag;
    assign m_alarm_flag    = res_reg.alarm_flag;
    assign m_mode_code     = res_reg.mode_code;
    assign m_alarm_report  = res_reg.alarm_report;

`ifndef ASSERT_OFF
    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item missing from input register");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("processed item missing from result register");
`endif

endmodule

/* src/tafsm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tafsm_cfg_regs
// Configuration register file: thresholds and dwell times, written through
// a valid/ready write channel.
// ----------------------------------------------------------------------------
module tafsm_cfg_regs
    import tafsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRE_THR:   cfg_next.prealarm_threshold = cfg_data[TEMP_W-1:0];
                REG_ALM_THR:   cfg_next.alarm_threshold    = cfg_data[TEMP_W-1:0];
                REG_PRE_DWELL: cfg_next.prealarm_dwell_ms  = cfg_data[DWELL_W-1:0];
                REG_ALM_DWELL: cfg_next.alarm_dwell_ms     = cfg_data[DWELL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prealarm_threshold <= PRE_THR_RST;
            cfg_reg.alarm_threshold    <= ALM_THR_RST;
            cfg_reg.prealarm_dwell_ms  <= PRE_DWELL_RST;
            cfg_reg.alarm_dwell_ms     <= ALM_DWELL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/tafsm_core.sv */
// ----------------------------------------------------------------------------
// tafsm_core
// Alarm state machine: state, entry flag, tracking start time and the two
// indication flags; one transition per item, result formed combinationally.
// ----------------------------------------------------------------------------
module tafsm_core
    import tafsm_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CmpW = (TIME_BITS > DWELL_W) ? TIME_BITS : DWELL_W;

    mode_t                mode_reg, mode_next;
    logic                 entry_reg, entry_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 pre_reg, pre_next;
    logic                 alm_reg, alm_next;
    logic                 ran_alarm;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] start_eff;
    logic [TIME_BITS-1:0] elapsed;
    logic                 pre_dwell_done;
    logic                 alm_dwell_done;
    logic                 above_pre;
    logic                 above_alm;

    assign now_t     = TIME_BITS'(item.now_ms);
    assign start_eff = entry_reg ? now_t : start_reg;
    assign elapsed   = now_t - start_eff;
    assign pre_dwell_done = CmpW'(elapsed) >= CmpW'(cfg.prealarm_dwell_ms);
    assign alm_dwell_done = CmpW'(elapsed) >= CmpW'(cfg.alarm_dwell_ms);
    assign above_pre = $signed(item.temperature) >= $signed(cfg.prealarm_threshold);
    assign above_alm = $signed(item.temperature) >= $signed(cfg.alarm_threshold);

    always_comb begin
        mode_next  = mode_reg;
        entry_next = 1'b0;
        start_next = start_reg;
        pre_next   = pre_reg;
        alm_next   = alm_reg;
        ran_alarm  = 1'b0;
        unique case (mode_reg)
            ST_TRACK_PRE: begin
                start_next = start_eff;
                if (!above_pre) begin
                    mode_next  = ST_NORMAL;
                    entry_next = 1'b1;
                end else if (pre_dwell_done) begin
                    mode_next  = ST_PRE;
                    entry_next = 1'b1;
                end
            end
            ST_PRE: begin
                if (entry_reg) begin
                    pre_next = 1'b1;
                end
                if (!above_pre) begin
                    mode_next  = ST_NORMAL;
                    entry_next = 1'b1;
                end else if (above_alm) begin
                    mode_next  = ST_TRACK_ALARM;
                    entry_next = 1'b1;
                end
            end
            ST_TRACK_ALARM: begin
                start_next = start_eff;
                if (!above_alm) begin
                    mode_next  = ST_PRE;
                    entry_next = 1'b1;
                end else if (alm_dwell_done) begin
                    mode_next  = ST_ALARM;
                    entry_next = 1'b1;
                end
            end
            ST_ALARM: begin
                ran_alarm = 1'b1;
                if (entry_reg) begin
                    pre_next = 1'b0;
                    alm_next = 1'b1;
                end
                if (item.button_pressed) begin
                    mode_next  = ST_NORMAL;
                    entry_next = 1'b1;
                end
            end
            default: begin
                mode_next = ST_NORMAL;
                if (entry_reg) begin
                    pre_next = 1'b0;
                    alm_next = 1'b0;
                end
                if (above_pre) begin
                    mode_next  = ST_TRACK_PRE;
                    entry_next = 1'b1;
                end
            end
        endcase
    end

    assign result.prealarm_flag = pre_next;
    assign result.alarm_flag    = alm_next;
    assign result.mode_code     = mode_to_code(mode_next);
    assign result.alarm_report  = ran_alarm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ST_NORMAL;
            entry_reg <= 1'b1;
            start_reg <= '0;
            pre_reg   <= 1'b0;
            alm_reg   <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            entry_reg <= entry_next;
            start_reg <= start_next;
            pre_reg   <= pre_next;
            alm_reg   <= alm_next;
        end
    end

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pre_reg && alm_reg))
        else $error("pre-alarm and alarm flags both set");

    a_alarm_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == ST_ALARM && !item.button_pressed |=> mode_reg == ST_ALARM)
        else $error("alarm state left without button");

    a_pre_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == ST_PRE |=> pre_reg)
        else $error("pre-alarm flag clear after pre-alarm tick");

    a_alarm_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == ST_ALARM |=> alm_reg)
        else $error("alarm flag clear after alarm tick");
`endif

endmodule

/* verif/temperature_alarm_fsm_tb.sv */
// ----------------------------------------------------------------------------
// temperature_alarm_fsm_tb
// Self-checking bench for the thermal alarm state machine. A queue-fed driver
// sends tick items with random gaps and a clocked monitor takes results with
// random stalls and two long hold-offs. A cycle-free model of the five states
// predicts each result. Thresholds and dwell times are rewritten between
// phases, at their extremes and at random values.
// ----------------------------------------------------------------------------
module temperature_alarm_fsm_tb
    import tafsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEMP_MIN     = -880;
    localparam int TEMP_MAX     = 2000;
    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [TEMP_W-1:0]     s_temperature    = '0;
    logic [NOW_W-1:0]      s_now_ms         = '0;
    logic                  s_button_pressed = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic                  m_prealarm_flag;
    logic                  m_alarm_flag;
    logic [MODE_W-1:0]     m_mode_code;
    logic                  m_alarm_report;

    // model copy of the registers and the state machine
    logic signed [TEMP_W-1:0] thr_pre   = PRE_THR_RST;
    logic signed [TEMP_W-1:0] thr_alm   = ALM_THR_RST;
    logic [DWELL_W-1:0]       dwell_pre = PRE_DWELL_RST;
    logic [DWELL_W-1:0]       dwell_alm = ALM_DWELL_RST;
    logic [MODE_W-1:0]        fsm_mode      = CODE_NORMAL;
    logic                     fsm_entry     = 1'b1;
    logic [NOW_W-1:0]         fsm_start     = '0;
    logic                     fsm_pre_flag  = 1'b0;
    logic                     fsm_alm_flag  = 1'b0;

    item_t   tick_queue [$];
    result_t pending_results [$];
    item_t   cur_tick;

    int src_wait = 0;
    int src_calm = 0;
    int sink_wait = 0;
    int sink_calm = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int mode_hits [5];

    wire any_accept = (s_valid && s_ready) || (m_valid && m_ready) ||
                      (cfg_valid && cfg_ready);

    temperature_alarm_fsm u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_temperature    (s_temperature),
        .s_now_ms         (s_now_ms),
        .s_button_pressed (s_button_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prealarm_flag  (m_prealarm_flag),
        .m_alarm_flag     (m_alarm_flag),
        .m_mode_code      (m_mode_code),
        .m_alarm_report   (m_alarm_report)
    );

    always #6 aclk = ~aclk;

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic cfg_t make_cfg(input int pre_thr, input int alm_thr,
                                      input logic [DWELL_W-1:0] pre_dw,
                                      input logic [DWELL_W-1:0] alm_dw);
        cfg_t c;
        c.prealarm_threshold = pre_thr[TEMP_W-1:0];
        c.alarm_threshold    = alm_thr[TEMP_W-1:0];
        c.prealarm_dwell_ms  = pre_dw;
        c.alarm_dwell_ms     = alm_dw;
        return c;
    endfunction

    task automatic move_to(input logic [MODE_W-1:0] next_mode);
        fsm_mode  = next_mode;
        fsm_entry = 1'b1;
    endtask

    task automatic advance_alarm_fsm(input item_t tick, output result_t res);
        logic signed [TEMP_W-1:0] temp;
        logic [NOW_W-1:0]         elapsed;
        logic                     in_alarm;
        temp     = tick.temperature;
        in_alarm = 1'b0;
        case (fsm_mode)
            CODE_TRACK_PRE: begin
                if (fsm_entry) begin
                    fsm_start = tick.now_ms;
                    fsm_entry = 1'b0;
                end
                elapsed = tick.now_ms - fsm_start;
                if (temp < thr_pre) move_to(CODE_NORMAL);
                else if (elapsed >= dwell_pre) move_to(CODE_PRE);
            end
            CODE_PRE: begin
                if (fsm_entry) begin
                    fsm_pre_flag = 1'b1;
                    fsm_entry    = 1'b0;
                end
                if (temp < thr_pre) move_to(CODE_NORMAL);
                else if (temp >= thr_alm) move_to(CODE_TRACK_ALARM);
            end
            CODE_TRACK_ALARM: begin
                if (fsm_entry) begin
                    fsm_start = tick.now_ms;
                    fsm_entry = 1'b0;
                end
                elapsed = tick.now_ms - fsm_start;
                if (temp < thr_alm) move_to(CODE_PRE);
                else if (elapsed >= dwell_alm) move_to(CODE_ALARM);
            end
            CODE_ALARM: begin
                in_alarm = 1'b1;
                if (fsm_entry) begin
                    fsm_pre_flag = 1'b0;
                    fsm_alm_flag = 1'b1;
                    fsm_entry    = 1'b0;
                end
                if (tick.button_pressed) move_to(CODE_NORMAL);
            end
            default: begin
                fsm_mode = CODE_NORMAL;
                if (fsm_entry) begin
                    fsm_pre_flag = 1'b0;
                    fsm_alm_flag = 1'b0;
                    fsm_entry    = 1'b0;
                end
                if (temp >= thr_pre) move_to(CODE_TRACK_PRE);
            end
        endcase
        res.prealarm_flag = fsm_pre_flag;
        res.alarm_flag    = fsm_alm_flag;
        res.mode_code     = fsm_mode;
        res.alarm_report  = in_alarm;
    endtask

    task automatic push_tick(input int temp, input logic [NOW_W-1:0] stamp,
                             input logic button);
        item_t t;
        t.temperature    = temp[TEMP_W-1:0];
        t.now_ms         = stamp;
        t.button_pressed = button;
        tick_queue.push_back(t);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (tick_queue.size() != 0 || s_valid || pending_results.size() != 0);
    endtask

    task automatic write_config(input cfg_t c);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < 4; i++) begin
            idx  = i[CFG_IDX_W-1:0];
            word = $urandom();
            case (idx)
                REG_PRE_THR:   word[TEMP_W-1:0] = c.prealarm_threshold;
                REG_ALM_THR:   word[TEMP_W-1:0] = c.alarm_threshold;
                REG_PRE_DWELL: word = c.prealarm_dwell_ms;
                default:       word = c.alarm_dwell_ms;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            do @(posedge aclk);
            while (!cfg_ready);
            case (idx)
                REG_PRE_THR:   thr_pre   = word[TEMP_W-1:0];
                REG_ALM_THR:   thr_alm   = word[TEMP_W-1:0];
                REG_PRE_DWELL: dwell_pre = word;
                default:       dwell_alm = word;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_random_ticks(input cfg_t c, input int count);
        int               lvl [2];
        int               lo;
        int               hi;
        int               pick;
        int               run_left;
        int               roll;
        logic [NOW_W-1:0] stamp;
        lvl[0]   = $signed(c.prealarm_threshold);
        lvl[1]   = $signed(c.alarm_threshold);
        run_left = 0;
        lo       = TEMP_MIN;
        hi       = TEMP_MAX;
        if ($urandom_range(0, 1) == 0) stamp = $urandom();
        else stamp = 32'hFFFF_FFFF - $urandom_range(0, 400);
        for (int n = 0; n < count; n++) begin
            // hold the temperature in one band for a run of ticks
            if (run_left == 0) begin
                run_left = $urandom_range(1, 15);
                pick     = lvl[$urandom_range(0, 1)];
                lo       = TEMP_MIN;
                hi       = TEMP_MAX;
                case ($urandom_range(0, 5))
                    1, 2: lo = pick;
                    3: begin
                        if (pick > TEMP_MIN) hi = pick - 1;
                    end
                    4: begin
                        lo = (lvl[0] < lvl[1]) ? lvl[0] : lvl[1];
                        hi = (lvl[0] < lvl[1]) ? lvl[1] - 1 : lvl[0] - 1;
                        if (hi < lo) hi = TEMP_MAX;
                    end
                    5: begin
                        lo = pick;
                        hi = pick;
                    end
                    default: ;
                endcase
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) stamp = $urandom();
            else if (roll < 10) stamp = stamp + $urandom_range(0, 6000);
            else stamp = stamp + $urandom_range(0, 12);
            push_tick(lo + int'($urandom_range(0, hi - lo)), stamp,
                      $urandom_range(0, 7) == 0);
        end
    endtask

    always @(posedge aclk) begin : driver
        item_t   nxt;
        result_t want;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                advance_alarm_fsm(cur_tick, want);
                pending_results.push_back(want);
                ticks_sent++;
                src_wait = draw_gap(src_calm);
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    nxt              = tick_queue.pop_front();
                    cur_tick         = nxt;
                    s_temperature    <= nxt.temperature;
                    s_now_ms         <= nxt.now_ms;
                    s_button_pressed <= nxt.button_pressed;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result item with no tick waiting");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_prealarm_flag !== want.prealarm_flag) begin
                        $error("prealarm_flag: expected %0b, actual %0b",
                               want.prealarm_flag, m_prealarm_flag);
                        mismatches++;
                    end
                    if (m_alarm_flag !== want.alarm_flag) begin
                        $error("alarm_flag: expected %0b, actual %0b",
                               want.alarm_flag, m_alarm_flag);
                        mismatches++;
                    end
                    if (m_mode_code !== want.mode_code) begin
                        $error("mode_code: expected %0d, actual %0d",
                               want.mode_code, m_mode_code);
                        mismatches++;
                    end
                    if (m_alarm_report !== want.alarm_report) begin
                        $error("alarm_report: expected %0b, actual %0b",
                               want.alarm_report, m_alarm_report);
                        mismatches++;
                    end
                end
                if (m_mode_code <= CODE_ALARM) mode_hits[m_mode_code]++;
                // long hold-off so that both stages fill and s_ready drops
                if (results_seen == 300 || results_seen == 900) sink_wait = LONG_HOLD;
                else sink_wait = draw_gap(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || any_accept) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        cfg_t c;
        int   pt;
        int   at;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: full walk up to alarm and out again
        push_tick(480, 32'hFFFF_F000, 1'b1);
        push_tick(2000, 32'hFFFF_FF00, 1'b0);
        push_tick(800, 32'h0000_1200, 1'b0);
        push_tick(800, 32'h0000_1288, 1'b0);
        push_tick(479, 32'h0000_1300, 1'b0);
        push_tick(0, 32'h0000_1310, 1'b0);
        push_tick(2000, 32'd100, 1'b0);
        push_tick(2000, 32'd100, 1'b0);
        push_tick(2000, 32'd5100, 1'b0);
        push_tick(2000, 32'd5100, 1'b0);
        push_tick(799, 32'd5200, 1'b0);
        push_tick(800, 32'd5300, 1'b0);
        push_tick(900, 32'd5300, 1'b0);
        push_tick(900, 32'd10299, 1'b0);
        push_tick(900, 32'd10300, 1'b0);
        push_tick(-880, 32'hFFFF_FFFF, 1'b0);
        push_tick(-880, 32'h7FFF_FFFF, 1'b1);
        wait_idle();

        // lowest pre-alarm threshold, highest alarm threshold, zero dwell
        c = make_cfg(TEMP_MIN, TEMP_MAX, '0, '0);
        write_config(c);
        push_tick(-880, 32'h5555_5555, 1'b0);
        push_tick(-880, 32'hAAAA_AAAA, 1'b0);
        push_tick(2000, 32'h0, 1'b0);
        push_tick(2000, 32'h0, 1'b0);
        push_tick(2000, 32'h1, 1'b1);
        queue_random_ticks(c, 150);
        wait_idle();

        // crossed thresholds, longest dwell
        c = make_cfg(TEMP_MAX, TEMP_MIN, '1, '1);
        write_config(c);
        push_tick(2000, 32'd1000, 1'b0);
        push_tick(2000, 32'd1000, 1'b0);
        push_tick(2000, 32'd999, 1'b0);
        push_tick(2000, 32'd999, 1'b0);
        push_tick(-880, 32'd7, 1'b0);
        push_tick(-880, 32'd6, 1'b0);
        queue_random_ticks(c, 100);
        wait_idle();

        c = make_cfg(PRE_THR_RST, ALM_THR_RST, PRE_DWELL_RST, ALM_DWELL_RST);
        write_config(c);
        queue_random_ticks(c, 150);

        for (int p = 0; p < 6; p++) begin
            pt = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
            if ($urandom_range(0, 3) != 0) at = pt + int'($urandom_range(0, 400));
            else at = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
            if (at > TEMP_MAX) at = TEMP_MAX;
            c = make_cfg(pt, at, $urandom_range(0, 40), $urandom_range(0, 40));
            wait_idle();
            write_config(c);
            queue_random_ticks(c, 150);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d ticks and %0d results under %0d register settings",
                 ticks_sent, results_seen, settings_used);
        $display("ticks ending in normal %0d, track pre %0d, pre %0d, track alarm %0d, alarm %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
